### sv/aabbt_pkg.sv
// Shared widths, types and the narrowing function of the transformed box pipeline.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package aabbt_pkg;

   // Field and datapath widths
   localparam int AXES     = 3;
   localparam int COORD_W  = 32;
   localparam int ENTRY_W  = 16;
   localparam int BASIS_W  = AXES * ENTRY_W;
   localparam int CORNER_W = COORD_W + 1;
   localparam int PROD_W   = CORNER_W + ENTRY_W;
   localparam int WIDE_W   = PROD_W + 2;

   // Fraction bits of a matrix entry; the narrowing drops exactly these
   localparam int MATRIX_FRAC_BITS = 14;

   // Pipeline layout: corner stage, lane stages, output stage
   localparam int LANE_STAGES  = 6;
   localparam int PIPE_STAGES  = LANE_STAGES + 2;
   localparam int CORNER_STAGE = 0;
   localparam int MERGE_STAGE  = PIPE_STAGES - 1;

   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic        [BASIS_W-1:0]  basis_type;
   typedef logic signed [CORNER_W-1:0] corner_type;
   typedef logic signed [ENTRY_W-1:0]  entry_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [WIDE_W-1:0]   wide_type;

   typedef struct packed {
      coord_type value;
      logic      sat;
   } narrow_type;

   typedef struct packed {
      coord_type center;
      coord_type extent;
      logic      sat;
   } lane_result_type;

   // Round to nearest (ties up), drop the matrix fraction, clamp to 32 bits
   function automatic narrow_type narrow(input wide_type wide);
      logic signed [WIDE_W:0]                  rounded;
      logic        [WIDE_W-MATRIX_FRAC_BITS:0] shifted;
      logic        [WIDE_W-COORD_W-MATRIX_FRAC_BITS+1:0] upper;
      narrow_type                              res;
      rounded = $signed({wide[WIDE_W-1], wide})
              + $signed({{(WIDE_W+1-MATRIX_FRAC_BITS){1'b0}}, 1'b1,
                         {(MATRIX_FRAC_BITS-1){1'b0}}});
      shifted = rounded[WIDE_W:MATRIX_FRAC_BITS];
      upper   = shifted[WIDE_W-MATRIX_FRAC_BITS:COORD_W-1];
      if ((&upper) || !(|upper)) begin
         res.value = shifted[COORD_W-1:0];
         res.sat   = 1'b0;
      end else begin
         res.value = shifted[WIDE_W-MATRIX_FRAC_BITS] ? {1'b1, {(COORD_W-1){1'b0}}}
                                                     : {1'b0, {(COORD_W-1){1'b1}}};
         res.sat   = 1'b1;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### sv/aabbt_req_if.sv
// Request channel: valid/ready handshake carrying one local box and its basis columns.
// Depends on aabbt_pkg for field types.
`default_nettype none

interface aabbt_req_if;
   logic                 valid;
   logic                 ready;
   aabbt_pkg::coord_type center_x;
   aabbt_pkg::coord_type center_y;
   aabbt_pkg::coord_type center_z;
   aabbt_pkg::coord_type extent_x;
   aabbt_pkg::coord_type extent_y;
   aabbt_pkg::coord_type extent_z;
   aabbt_pkg::basis_type basis_x;
   aabbt_pkg::basis_type basis_y;
   aabbt_pkg::basis_type basis_z;

   modport source (
      output valid, center_x, center_y, center_z, extent_x, extent_y, extent_z,
             basis_x, basis_y, basis_z,
      input  ready
   );

   modport sink (
      input  valid, center_x, center_y, center_z, extent_x, extent_y, extent_z,
             basis_x, basis_y, basis_z,
      output ready
   );
endinterface

`default_nettype wire

### sv/aabbt_rsp_if.sv
// Response channel: valid/ready handshake carrying one world box and the clamp flag.
// Depends on aabbt_pkg for field types.
`default_nettype none

interface aabbt_rsp_if;
   logic                 valid;
   logic                 ready;
   aabbt_pkg::coord_type world_center_x;
   aabbt_pkg::coord_type world_center_y;
   aabbt_pkg::coord_type world_center_z;
   aabbt_pkg::coord_type world_extent_x;
   aabbt_pkg::coord_type world_extent_y;
   aabbt_pkg::coord_type world_extent_z;
   logic                 saturated;

   modport source (
      output valid, world_center_x, world_center_y, world_center_z,
             world_extent_x, world_extent_y, world_extent_z, saturated,
      input  ready
   );

   modport sink (
      input  valid, world_center_x, world_center_y, world_center_z,
             world_extent_x, world_extent_y, world_extent_z, saturated,
      output ready
   );
endinterface

`default_nettype wire

### sv/aabbt_corners.sv
// Front stage: forms the local min/max corners and unpacks the matrix entries.
// Depends on aabbt_pkg.
`default_nettype none

module aabbt_corners (
   input  wire logic                  clock,
   input  wire logic                  adv,
   input  wire aabbt_pkg::coord_type  center [aabbt_pkg::AXES],
   input  wire aabbt_pkg::coord_type  extent [aabbt_pkg::AXES],
   input  wire aabbt_pkg::basis_type  basis  [aabbt_pkg::AXES],
   output aabbt_pkg::corner_type      lo_ff  [aabbt_pkg::AXES],
   output aabbt_pkg::corner_type      hi_ff  [aabbt_pkg::AXES],
   output aabbt_pkg::entry_type       entry_ff [aabbt_pkg::AXES][aabbt_pkg::AXES]
);

   aabbt_pkg::corner_type lo_in    [aabbt_pkg::AXES];
   aabbt_pkg::corner_type hi_in    [aabbt_pkg::AXES];
   aabbt_pkg::entry_type  entry_in [aabbt_pkg::AXES][aabbt_pkg::AXES];

   // Corners are exact in one extra bit; entry [i][j] is world axis i of column j
   always_comb begin
      for (int j = 0; j < aabbt_pkg::AXES; j++) begin
         lo_in[j] = $signed({center[j][aabbt_pkg::COORD_W-1], center[j]})
                  - $signed({extent[j][aabbt_pkg::COORD_W-1], extent[j]});
         hi_in[j] = $signed({center[j][aabbt_pkg::COORD_W-1], center[j]})
                  + $signed({extent[j][aabbt_pkg::COORD_W-1], extent[j]});
         for (int i = 0; i < aabbt_pkg::AXES; i++) begin
            entry_in[i][j] = basis[j][aabbt_pkg::ENTRY_W*i +: aabbt_pkg::ENTRY_W];
         end
      end
   end

   // Hold while the next stage is stalled
   always_ff @(posedge clock) begin
      if (adv) begin
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

### sv/aabbt_lane.sv
// One world-axis lane: products, ordering, sums, center/extent and narrowing.
// Depends on aabbt_pkg.
`default_nettype none

module aabbt_lane (
   input  wire logic                              clock,
   input  wire logic [aabbt_pkg::LANE_STAGES-1:0] adv,
   input  wire aabbt_pkg::corner_type             lo    [aabbt_pkg::AXES],
   input  wire aabbt_pkg::corner_type             hi    [aabbt_pkg::AXES],
   input  wire aabbt_pkg::entry_type              entry [aabbt_pkg::AXES],
   output aabbt_pkg::lane_result_type             result_ff
);

   aabbt_pkg::prod_type        prod_a_in [aabbt_pkg::AXES];
   aabbt_pkg::prod_type        prod_b_in [aabbt_pkg::AXES];
   aabbt_pkg::prod_type        prod_a_ff [aabbt_pkg::AXES];
   aabbt_pkg::prod_type        prod_b_ff [aabbt_pkg::AXES];
   aabbt_pkg::prod_type        ord_lo_in [aabbt_pkg::AXES];
   aabbt_pkg::prod_type        ord_hi_in [aabbt_pkg::AXES];
   aabbt_pkg::prod_type        ord_lo_ff [aabbt_pkg::AXES];
   aabbt_pkg::prod_type        ord_hi_ff [aabbt_pkg::AXES];
   aabbt_pkg::wide_type        sum_lo_in, sum_hi_in, sum_lo_ff, sum_hi_ff;
   logic signed [aabbt_pkg::WIDE_W:0] pair_sum;
   aabbt_pkg::wide_type        ctr_in, ctr_ff, max_in, max_ff;
   aabbt_pkg::wide_type        ext_in, ext_ff, ctr2_in, ctr2_ff;
   aabbt_pkg::narrow_type      nc, ne;
   aabbt_pkg::lane_result_type result_in;

   // Multiply both corners by the matrix entry of each column
   always_comb begin
      for (int j = 0; j < aabbt_pkg::AXES; j++) begin
         prod_a_in[j] = entry[j] * lo[j];
         prod_b_in[j] = entry[j] * hi[j];
      end
   end

   // Order each product pair into smaller and larger
   always_comb begin
      for (int j = 0; j < aabbt_pkg::AXES; j++) begin
         if (prod_a_ff[j] < prod_b_ff[j]) begin
            ord_lo_in[j] = prod_a_ff[j];
            ord_hi_in[j] = prod_b_ff[j];
         end else begin
            ord_lo_in[j] = prod_b_ff[j];
            ord_hi_in[j] = prod_a_ff[j];
         end
      end
   end

   // Accumulate the world minimum and maximum
   always_comb begin
      sum_lo_in = aabbt_pkg::WIDE_W'(ord_lo_ff[0]) + aabbt_pkg::WIDE_W'(ord_lo_ff[1])
                + aabbt_pkg::WIDE_W'(ord_lo_ff[2]);
      sum_hi_in = aabbt_pkg::WIDE_W'(ord_hi_ff[0]) + aabbt_pkg::WIDE_W'(ord_hi_ff[1])
                + aabbt_pkg::WIDE_W'(ord_hi_ff[2]);
   end

   // Center is the floor of the half sum; extent is max less center
   always_comb begin
      pair_sum = $signed({sum_lo_ff[aabbt_pkg::WIDE_W-1], sum_lo_ff})
               + $signed({sum_hi_ff[aabbt_pkg::WIDE_W-1], sum_hi_ff});
      ctr_in   = pair_sum[aabbt_pkg::WIDE_W:1];
      max_in   = sum_hi_ff;
      ext_in   = max_ff - ctr_ff;
      ctr2_in  = ctr_ff;
   end

   // Narrow both values back to Q16.16
   always_comb begin
      nc = aabbt_pkg::narrow(ctr2_ff);
      ne = aabbt_pkg::narrow(ext_ff);
      result_in.center = nc.value;
      result_in.extent = ne.value;
      result_in.sat    = nc.sat | ne.sat;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
      if (adv[1]) begin
         ord_lo_ff <= ord_lo_in;
         ord_hi_ff <= ord_hi_in;
      end
      if (adv[2]) begin
         sum_lo_ff <= sum_lo_in;
         sum_hi_ff <= sum_hi_in;
      end
      if (adv[3]) begin
         ctr_ff <= ctr_in;
         max_ff <= max_in;
      end
      if (adv[4]) begin
         ext_ff  <= ext_in;
         ctr2_ff <= ctr2_in;
      end
      if (adv[5]) begin
         result_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

### sv/aabbt_merge.sv
// Output stage: gathers the three lane results and folds their clamp flags.
// Depends on aabbt_pkg.
`default_nettype none

module aabbt_merge (
   input  wire logic                        clock,
   input  wire logic                        adv,
   input  wire aabbt_pkg::lane_result_type  lane [aabbt_pkg::AXES],
   output aabbt_pkg::coord_type             center_ff [aabbt_pkg::AXES],
   output aabbt_pkg::coord_type             extent_ff [aabbt_pkg::AXES],
   output logic                             sat_ff
);

   aabbt_pkg::coord_type center_in [aabbt_pkg::AXES];
   aabbt_pkg::coord_type extent_in [aabbt_pkg::AXES];
   logic                 sat_in;

   // Collect lane values; raise the flag if any lane clamped
   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < aabbt_pkg::AXES; i++) begin
         center_in[i] = lane[i].center;
         extent_in[i] = lane[i].extent;
         sat_in       = sat_in | lane[i].sat;
      end
   end

   // Hold while the response is not taken
   always_ff @(posedge clock) begin
      if (adv) begin
         center_ff <= center_in;
         extent_ff <= extent_in;
         sat_ff    <= sat_in;
      end
   end

endmodule

`default_nettype wire

### sv/aabb_linear_transform.sv
// Top level of the transformed axis-aligned box pipeline (linear part only).
// Depends on aabbt_pkg, aabbt_req_if, aabbt_rsp_if, aabbt_corners, aabbt_lane, aabbt_merge.
`default_nettype none

// Takes one local box (center, half extents, three basis columns) per transaction and
// returns the world-space box of its 3x3 linear transform, with no translation added.
// The block is an eight-stage pipeline: one corner stage, six stages in each of three
// parallel lanes (one lane per world axis, six 16x33-bit multipliers each), and one
// output register that merges the lanes. Throughput is one transaction per cycle while
// responses are taken; a stalled response only stops the stages behind it once all of
// them are full, so bubbles are squeezed out. Results are rounded to nearest (ties up)
// and clamped to the signed 32-bit Q16.16 range, and saturated reports any clamp.
// There is no configuration and no state between boxes.
module aabb_linear_transform (
   input  wire logic clock,
   input  wire logic reset,
   aabbt_req_if.sink   req_bus,
   aabbt_rsp_if.source rsp_bus
);

   logic [aabbt_pkg::PIPE_STAGES-1:0] valid_ff, valid_in, adv;

   aabbt_pkg::coord_type       center [aabbt_pkg::AXES];
   aabbt_pkg::coord_type       extent [aabbt_pkg::AXES];
   aabbt_pkg::basis_type       basis  [aabbt_pkg::AXES];
   aabbt_pkg::corner_type      lo     [aabbt_pkg::AXES];
   aabbt_pkg::corner_type      hi     [aabbt_pkg::AXES];
   aabbt_pkg::entry_type       entry  [aabbt_pkg::AXES][aabbt_pkg::AXES];
   aabbt_pkg::lane_result_type lane_result [aabbt_pkg::AXES];
   aabbt_pkg::coord_type       world_center [aabbt_pkg::AXES];
   aabbt_pkg::coord_type       world_extent [aabbt_pkg::AXES];
   logic                       sat;

   // Stage advance: a stage loads when it is empty or its successor moves
   always_comb begin
      adv[aabbt_pkg::MERGE_STAGE] = !valid_ff[aabbt_pkg::MERGE_STAGE] || rsp_bus.ready;
      for (int k = aabbt_pkg::MERGE_STAGE - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   // Move valid flags along with the data
   always_comb begin
      valid_in[0] = adv[0] ? req_bus.valid : valid_ff[0];
      for (int k = 1; k < aabbt_pkg::PIPE_STAGES; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_bus.ready = adv[aabbt_pkg::CORNER_STAGE];
   assign rsp_bus.valid = valid_ff[aabbt_pkg::MERGE_STAGE];

   assign center = '{req_bus.center_x, req_bus.center_y, req_bus.center_z};
   assign extent = '{req_bus.extent_x, req_bus.extent_y, req_bus.extent_z};
   assign basis  = '{req_bus.basis_x, req_bus.basis_y, req_bus.basis_z};

   aabbt_corners u_corners (
      .clock    (clock),
      .adv      (adv[aabbt_pkg::CORNER_STAGE]),
      .center   (center),
      .extent   (extent),
      .basis    (basis),
      .lo_ff    (lo),
      .hi_ff    (hi),
      .entry_ff (entry)
   );

   for (genvar i = 0; i < aabbt_pkg::AXES; i++) begin : g_lane
      aabbt_lane u_lane (
         .clock     (clock),
         .adv       (adv[aabbt_pkg::LANE_STAGES:1]),
         .lo        (lo),
         .hi        (hi),
         .entry     (entry[i]),
         .result_ff (lane_result[i])
      );
   end

   aabbt_merge u_merge (
      .clock     (clock),
      .adv       (adv[aabbt_pkg::MERGE_STAGE]),
      .lane      (lane_result),
      .center_ff (world_center),
      .extent_ff (world_extent),
      .sat_ff    (sat)
   );

   assign rsp_bus.world_center_x = world_center[0];
   assign rsp_bus.world_center_y = world_center[1];
   assign rsp_bus.world_center_z = world_center[2];
   assign rsp_bus.world_extent_x = world_extent[0];
   assign rsp_bus.world_extent_y = world_extent[1];
   assign rsp_bus.world_extent_z = world_extent[2];
   assign rsp_bus.saturated      = sat;

   // Back-pressure reaches the request side only when every stage is occupied
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (&valid_ff))
      else $error("request stalled with an empty pipeline stage");

   // World half extents are never negative
   a_extent_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (!rsp_bus.world_extent_x[aabbt_pkg::COORD_W-1] &&
                         !rsp_bus.world_extent_y[aabbt_pkg::COORD_W-1] &&
                         !rsp_bus.world_extent_z[aabbt_pkg::COORD_W-1]))
      else $error("negative world extent");

   // A taken response with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !valid_ff[aabbt_pkg::MERGE_STAGE-1])
      |=> !rsp_bus.valid)
      else $error("response repeated after it was taken");

endmodule

`default_nettype wire
